@@ sv/b3sa_pkg.sv @@
// Shared types and constants for the 3x3 box-sum peak finder.
package b3sa_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int PIXEL_BITS   = 16;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
    localparam int COLSUM_BITS  = PIXEL_BITS + 2;
    localparam int SUM_BITS     = PIXEL_BITS + 4;
    localparam int WIDTH_BITS   = COL_BITS + 1;
    localparam int HEIGHT_BITS  = ROW_BITS + 1;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = HEIGHT_BITS;
    localparam int LINE_BITS    = 2 * PIXEL_BITS;

    localparam logic signed [SUM_BITS-1:0] SUM_FLOOR = -SUM_BITS'(256);

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1024);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(1024);

    // One pixel in the compute stage, with its line-store reads
    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pixel;
        logic signed [PIXEL_BITS-1:0] p1;
        logic signed [PIXEL_BITS-1:0] p2;
        logic [COL_BITS-1:0]          col;
        logic [ROW_BITS-1:0]          row;
        logic                         x_ge1;
        logic                         x_last;
        logic                         y_ge1;
        logic                         y_ge2;
        logic                         y_last;
    } item_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic [COL_BITS-1:0]        col;
        logic [ROW_BITS-1:0]        row;
        logic                       hit;
    } tracker_t;

    localparam tracker_t TRACKER_RESET = '{sum: SUM_FLOOR, col: '0, row: '0, hit: 1'b0};

endpackage

@@ sv/b3sa_ram.sv @@
// Generic simple dual-port RAM with registered read.
module b3sa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ sv/b3sa_front.sv @@
// Input stage: raster counters, pixel register and the two-line store.
module b3sa_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  restart,
    input  logic [b3sa_pkg::COL_BITS-1:0]         last_col,
    input  logic [b3sa_pkg::ROW_BITS-1:0]         last_row,
    input  logic                                  in_accept,
    input  logic signed [b3sa_pkg::PIXEL_BITS-1:0] s_pixel,
    input  logic                                  adv,
    output logic                                  st_valid,
    output b3sa_pkg::item_t                       item
);
    import b3sa_pkg::*;

    logic [COL_BITS-1:0]          col_reg, col_next;
    logic [ROW_BITS-1:0]          row_reg, row_next;
    logic                         st_valid_reg, st_valid_next;
    logic                         fwd_reg, fwd_next;
    logic [LINE_BITS-1:0]         fwd_data_reg;
    logic signed [PIXEL_BITS-1:0] pix_reg;
    logic [COL_BITS-1:0]          x_reg;
    logic [ROW_BITS-1:0]          y_reg;
    logic                         x_ge1_reg, x_last_reg, y_ge1_reg, y_ge2_reg, y_last_reg;
    logic [LINE_BITS-1:0]         ram_rdata;
    logic [LINE_BITS-1:0]         rd_raw;
    logic [LINE_BITS-1:0]         wdata;

    // counters advance per accepted pixel
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (in_accept) begin
            if (col_reg == last_col) begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        if (in_accept) begin
            st_valid_next = 1'b1;
        end else if (adv) begin
            st_valid_next = 1'b0;
        end
    end

    // same column read while it is being written: width of one
    assign fwd_next = adv && (x_reg == col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            st_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            st_valid_reg <= st_valid_next;
            if (in_accept) begin
                fwd_reg <= fwd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pix_reg      <= s_pixel;
            x_reg        <= col_reg;
            y_reg        <= row_reg;
            x_ge1_reg    <= (col_reg != '0);
            x_last_reg   <= (col_reg == last_col);
            y_ge1_reg    <= (row_reg != '0);
            y_ge2_reg    <= (row_reg > ROW_BITS'(1));
            y_last_reg   <= (row_reg == last_row);
            fwd_data_reg <= wdata;
        end
    end

    assign rd_raw = fwd_reg ? fwd_data_reg : ram_rdata;
    // entry layout: upper half two rows back, lower half previous row
    assign wdata  = {rd_raw[PIXEL_BITS-1:0], pix_reg};

    b3sa_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (adv),
        .waddr (x_reg),
        .wdata (wdata),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        item.pixel  = pix_reg;
        item.p1     = rd_raw[PIXEL_BITS-1:0];
        item.p2     = rd_raw[LINE_BITS-1:PIXEL_BITS];
        item.col    = x_reg;
        item.row    = y_reg;
        item.x_ge1  = x_ge1_reg;
        item.x_last = x_last_reg;
        item.y_ge1  = y_ge1_reg;
        item.y_ge2  = y_ge2_reg;
        item.y_last = y_last_reg;
    end

    assign st_valid = st_valid_reg;
endmodule

@@ sv/b3sa_core.sv @@
// Compute stage: column-sum window, 3x3 sums and the two peak trackers.
module b3sa_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                restart,
    input  logic                adv,
    input  b3sa_pkg::item_t     item,
    output b3sa_pkg::tracker_t  main_next,
    output b3sa_pkg::tracker_t  tail_next
);
    import b3sa_pkg::*;

    logic signed [COLSUM_BITS-1:0] cw_reg [4];
    logic signed [COLSUM_BITS-1:0] cw_next [4];
    tracker_t                      main_reg, tail_reg;
    logic signed [PIXEL_BITS-1:0]  p1g, p2g;
    logic signed [COLSUM_BITS-1:0] a, b;
    logic signed [SUM_BITS-1:0]    s_main_mid, s_main_end, s_tail_mid, s_tail_end;
    logic [ROW_BITS-1:0]           row_up;
    logic [COL_BITS-1:0]           col_left;
    tracker_t                      main_mid;
    tracker_t                      tail_mid;

    function automatic tracker_t offer(input tracker_t t, input logic en,
                                       input logic signed [SUM_BITS-1:0] s,
                                       input logic [COL_BITS-1:0] c,
                                       input logic [ROW_BITS-1:0] r);
        tracker_t o;
        o = t;
        if (en && (s > $signed(t.sum))) begin
            o.sum = s;
            o.col = c;
            o.row = r;
            o.hit = 1'b1;
        end
        return o;
    endfunction

    always_comb begin
        p1g = item.y_ge1 ? item.p1 : '0;
        p2g = item.y_ge2 ? item.p2 : '0;
        a   = COLSUM_BITS'(item.pixel) + COLSUM_BITS'(p1g) + COLSUM_BITS'(p2g);
        b   = COLSUM_BITS'(item.pixel) + COLSUM_BITS'(p1g);

        s_main_mid = SUM_BITS'(cw_reg[0]) + SUM_BITS'(cw_reg[1]) + SUM_BITS'(a);
        s_main_end = SUM_BITS'(cw_reg[1]) + SUM_BITS'(a);
        s_tail_mid = SUM_BITS'(cw_reg[2]) + SUM_BITS'(cw_reg[3]) + SUM_BITS'(b);
        s_tail_end = SUM_BITS'(cw_reg[3]) + SUM_BITS'(b);

        row_up   = item.row - ROW_BITS'(1);
        col_left = item.col - COL_BITS'(1);

        // left neighbor's center first, then the row's last center
        main_mid  = offer(main_reg, item.y_ge1 && item.x_ge1, s_main_mid, col_left, row_up);
        main_next = offer(main_mid, item.y_ge1 && item.x_last, s_main_end, item.col, row_up);
        tail_mid  = offer(tail_reg, item.y_last && item.x_ge1, s_tail_mid, col_left, item.row);
        tail_next = offer(tail_mid, item.y_last && item.x_last, s_tail_end, item.col,
                          item.row);

        if (item.x_last) begin
            for (int i = 0; i < 4; i++) begin
                cw_next[i] = '0;
            end
        end else begin
            cw_next[0] = cw_reg[1];
            cw_next[1] = a;
            cw_next[2] = cw_reg[3];
            cw_next[3] = b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int i = 0; i < 4; i++) begin
                cw_reg[i] <= '0;
            end
            main_reg <= TRACKER_RESET;
            tail_reg <= TRACKER_RESET;
        end else if (adv) begin
            for (int i = 0; i < 4; i++) begin
                cw_reg[i] <= cw_next[i];
            end
            if (item.x_last && item.y_last) begin
                main_reg <= TRACKER_RESET;
                tail_reg <= TRACKER_RESET;
            end else begin
                main_reg <= main_next;
                tail_reg <= tail_next;
            end
        end
    end
endmodule

@@ sv/box3x3_sum_argmax.sv @@
// Result: the frame's result is registered as its last pixel leaves the compute stage.
// Throughput: one pixel per cycle; input stalls only if the previous frame's result
//   is still untaken when the next frame's last pixel reaches the compute stage.
// Line store: one 1024 x 32 RAM, read one column ahead, written in the compute stage.
// Reset: synchronous; config returns to 1024 x 1024, counters and trackers clear,
//   the line store is not cleared (unwritten entries are never used).
module box3x3_sum_argmax (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [b3sa_pkg::PIXEL_BITS-1:0]   s_pixel,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_found,
    output logic [b3sa_pkg::COL_BITS-1:0]            m_best_col,
    output logic [b3sa_pkg::ROW_BITS-1:0]            m_best_row,
    output logic signed [b3sa_pkg::SUM_BITS-1:0]     m_best_sum,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [b3sa_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [b3sa_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
    import b3sa_pkg::*;

    // configuration registers
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   cfg_write;
    logic                   restart;
    logic [COL_BITS-1:0]    last_col;
    logic [ROW_BITS-1:0]    last_row;

    // pipeline control
    logic     in_accept;
    logic     st_valid;
    logic     frame_end;
    logic     blocked;
    logic     adv;
    item_t    item;
    tracker_t main_next, tail_next;

    // result register: both trackers of the finished frame
    logic     m_valid_reg, m_valid_next;
    tracker_t res_main_reg, res_tail_reg;
    logic     tail_wins;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // any write to a defined register restarts the frame
    always_comb begin
        restart = 1'b0;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  restart = 1'b1;
                CFG_FRAME_HEIGHT: restart = 1'b1;
                default:          restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize saturates
    always_comb begin
        if (width_reg == '0) begin
            last_col = '0;
        end else if (width_reg > WIDTH_BITS'(MAX_WIDTH)) begin
            last_col = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_BITS'(width_reg - WIDTH_BITS'(1));
        end
        if (height_reg == '0) begin
            last_row = '0;
        end else if (height_reg > HEIGHT_BITS'(HEIGHT_LIMIT)) begin
            last_row = ROW_BITS'(HEIGHT_LIMIT - 1);
        end else begin
            last_row = ROW_BITS'(height_reg - HEIGHT_BITS'(1));
        end
    end

    // compute stage holds only when the frame's last pixel meets a full result register that m_ready does not drain
    assign frame_end = item.x_last && item.y_last;
    assign blocked   = st_valid && frame_end && m_valid_reg && !m_ready;
    assign adv       = st_valid && !blocked;
    assign s_ready   = !st_valid || adv;
    assign in_accept = s_valid && s_ready;

    b3sa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .last_col  (last_col),
        .last_row  (last_row),
        .in_accept (in_accept),
        .s_pixel   (s_pixel),
        .adv       (adv),
        .st_valid  (st_valid),
        .item      (item)
    );

    b3sa_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .adv       (adv),
        .item      (item),
        .main_next (main_next),
        .tail_next (tail_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv && frame_end) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && frame_end) begin
            res_main_reg <= main_next;
            res_tail_reg <= tail_next;
        end
    end

    // final-row tracker wins only on a strictly larger sum; a miss leaves it at the floor
    assign tail_wins  = $signed(res_tail_reg.sum) > $signed(res_main_reg.sum);
    assign m_valid    = m_valid_reg;
    assign m_found    = res_main_reg.hit || tail_wins;
    assign m_best_col = tail_wins ? res_tail_reg.col : res_main_reg.col;
    assign m_best_row = tail_wins ? res_tail_reg.row : res_main_reg.row;
    assign m_best_sum = tail_wins ? res_tail_reg.sum : res_main_reg.sum;

    a_ready_low_only_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready && frame_end))
        else $error("input stalled without a pending result");

    a_not_found_is_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_best_sum == SUM_FLOOR && m_best_col == '0
                                   && m_best_row == '0))
        else $error("empty result carries a location or sum");

    a_found_above_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_best_sum > SUM_FLOOR))
        else $error("found result at or below the floor");

    a_result_loads_on_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && frame_end) |=> m_valid_reg)
        else $error("frame end did not produce a result");

    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_best_col <= last_col && m_best_row <= last_row))
        else $error("best location outside the frame");
endmodule
